// ----- hdl/mcfts_pkg.sv -----
// Shared types, constants and codes of the frame trigger sequencer.
package mcfts_pkg;

	// Field widths
	localparam int CMD_W      = 2;
	localparam int PERIOD_W   = 24;
	localparam int OFFSET_W   = 21;
	localparam int CHAN_W     = 2;
	localparam int SEQ_W      = 32;

	// Configuration port
	localparam int NUM_REGS   = 3;
	localparam int PADDR_W    = 4;
	localparam int APB_DW     = 32;
	localparam int REG_IDX_W  = PADDR_W - 2;

	// Defaults
	localparam int NUM_CHANNELS_DEF = 4;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000000);

	// Command codes carried in the input request
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_CH1 = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_CH2 = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_CH3 = 2'd2;

	typedef logic [NUM_REGS-1:0][OFFSET_W-1:0] offs_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SEL,
		ST_SCAN,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_SPREAD,
		ST_GAP,
		ST_LAST_GAP,
		ST_FIRE
	} state_t;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_LOAD,
		OP_SEL,
		OP_SCAN,
		OP_SWAP_A,
		OP_SWAP_B,
		OP_SPREAD,
		OP_GAP,
		OP_LAST_GAP,
		OP_FIRE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic go_build;   // start request while idle
		logic go_fire;    // tick request that fires triggers
		logic scan_end;   // inner sort scan at last entry
		logic sort_end;   // last outer sort pass
		logic gap_end;    // gap pass at last entry
		logic fire_done;  // current trigger is the last of this tick
		logic out_free;   // output register can take a result
	} dp_status_t;

endpackage

// ----- hdl/multi_channel_frame_trigger_sequencer.sv -----
// Top level of the multi-channel frame trigger sequencer.
// Tick: a tick request is accepted in the idle state; when it fires, the controller goes to the fire state,
// which writes the triggers (up to NUM_CHANNELS) into the output register while that register has room.
// Start: slot build by selection sort over the shared table read port, in the load, select, scan, swap,
// spread and gap states, no request taken meanwhile. Stop: taken in the idle state, which it does not leave.
// Throughput: one request at a time, the next is taken as soon as the controller is idle.
// Reset (arst_n low, asynchronous): idle, disarmed, offsets 0, period 1000000, sequence 0.
module multi_channel_frame_trigger_sequencer import mcfts_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	// request stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [PERIOD_W-1:0] s_tdata,   // [23:0] period_us
	input  logic [CMD_W-1:0]    s_tuser,   // [1:0] command
	// trigger stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [SEQ_W-1:0]    m_tdata,   // [31:0] frame_seq
	output logic [CHAN_W-1:0]   m_tuser,   // [1:0] trigger_channel
	output logic                m_tlast
);

	offs_t      offsets;
	ctrl_cmd_t  cmd;
	dp_status_t status;

	mcfts_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.offsets (offsets)
	);

	mcfts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	mcfts_dp #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.command         (s_tuser),
		.period_us       (s_tdata),
		.offsets         (offsets),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.trigger_channel (m_tuser),
		.frame_seq       (m_tdata),
		.last            (m_tlast)
	);

endmodule

// ----- hdl/mcfts_cfg.sv -----
// APB register file holding the per-channel trigger offsets.
module mcfts_cfg import mcfts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,
	output offs_t              offsets
);

	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;
	offs_t                off_q;

	assign idx     = paddr[PADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign offsets = off_q;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_OFFSET_CH1: off_q[0] <= pwdata[OFFSET_W-1:0];
				REG_OFFSET_CH2: off_q[1] <= pwdata[OFFSET_W-1:0];
				REG_OFFSET_CH3: off_q[2] <= pwdata[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back
	always_comb begin
		unique case (idx)
			REG_OFFSET_CH1: prdata = APB_DW'(off_q[0]);
			REG_OFFSET_CH2: prdata = APB_DW'(off_q[1]);
			REG_OFFSET_CH3: prdata = APB_DW'(off_q[2]);
			default:        prdata = '0;
		endcase
	end

endmodule

// ----- hdl/mcfts_ctrl.sv -----
// Controller state machine: sequences slot build, tick handling and trigger firing.
module mcfts_ctrl import mcfts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_nx = state_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_ACCEPT;
					if (status.go_build) begin
						state_nx = ST_LOAD;
					end else if (status.go_fire) begin
						state_nx = ST_FIRE;
					end
				end
			end
			ST_LOAD: begin
				cmd.op   = OP_LOAD;
				state_nx = ST_SEL;
			end
			ST_SEL: begin
				cmd.op   = OP_SEL;
				state_nx = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.op = OP_SCAN;
				if (status.scan_end) begin
					state_nx = ST_SWAP_A;
				end
			end
			ST_SWAP_A: begin
				cmd.op   = OP_SWAP_A;
				state_nx = ST_SWAP_B;
			end
			ST_SWAP_B: begin
				cmd.op   = OP_SWAP_B;
				state_nx = status.sort_end ? ST_SPREAD : ST_SEL;
			end
			ST_SPREAD: begin
				cmd.op   = OP_SPREAD;
				state_nx = ST_GAP;
			end
			ST_GAP: begin
				cmd.op = OP_GAP;
				if (status.gap_end) begin
					state_nx = ST_LAST_GAP;
				end
			end
			ST_LAST_GAP: begin
				cmd.op   = OP_LAST_GAP;
				state_nx = ST_IDLE;
			end
			ST_FIRE: begin
				// one trigger per cycle while the output register has room
				if (status.out_free) begin
					cmd.op = OP_FIRE;
					if (status.fire_done) begin
						state_nx = ST_IDLE;
					end
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

// ----- hdl/mcfts_dp.sv -----
// Datapath: slot tables, selection sort, gap build, countdown and output register.
module mcfts_dp import mcfts_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           cmd,
	output dp_status_t          status,
	input  logic [CMD_W-1:0]    command,
	input  logic [PERIOD_W-1:0] period_us,
	input  offs_t               offsets,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CHAN_W-1:0]   trigger_channel,
	output logic [SEQ_W-1:0]    frame_seq,
	output logic                last
);

	localparam int IDX_W = $clog2(NUM_CHANNELS);
	localparam int CW    = (IDX_W < CHAN_W) ? CHAN_W : IDX_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);
	localparam logic [IDX_W-1:0] PEN_IDX  = IDX_W'(NUM_CHANNELS - 2);

	// Slot tables
	logic signed [OFFSET_W-1:0] t_q   [NUM_CHANNELS];
	logic [CW-1:0]              c_q   [NUM_CHANNELS];
	logic [PERIOD_W-1:0]        gap_q [NUM_CHANNELS];

	// Sort and build registers
	logic [IDX_W-1:0]           i_q, j_q, m_q;
	logic signed [OFFSET_W-1:0] min_q, ti_q, base_q, prev_q;
	logic [CW-1:0]              ci_q, cm_q;
	logic                       clamp_q;

	// Run state
	logic                running_q, armed_q, wrapped_q;
	logic [PERIOD_W-1:0] period_q, countdown_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [IDX_W-1:0]    slot_idx_q, n_q;

	// Output register
	logic                out_valid_q, last_q;
	logic [CHAN_W-1:0]   chan_q;
	logic [SEQ_W-1:0]    oseq_q;

	logic [IDX_W-1:0]           rd_addr, fire_idx;
	logic signed [OFFSET_W-1:0] rd_t;
	logic [CW-1:0]              rd_c;
	logic [PERIOD_W-1:0]        rd_gap;
	logic                       fire_wrap, wrapped_now, gap_nz, at_n_end, wrap_again;
	logic                       fire_last, disarm, out_free;
	logic signed [OFFSET_W:0]   d_gap, d_spread, d_last;
	logic [PERIOD_W-1:0]        gap_val, spread_val, last_val;
	logic [SEQ_W-1:0]           seq_fire;

	// Next slot to fire
	assign fire_wrap   = (slot_idx_q == LAST_IDX);
	assign fire_idx    = fire_wrap ? '0 : slot_idx_q + 1'b1;
	assign wrapped_now = wrapped_q | fire_wrap;
	assign seq_fire    = fire_wrap ? seq_q + 1'b1 : seq_q;

	// Shared read port of the offset and channel tables
	always_comb begin
		unique case (cmd.op)
			OP_SEL:           rd_addr = i_q;
			OP_SCAN, OP_GAP:  rd_addr = j_q;
			OP_SPREAD:        rd_addr = LAST_IDX;
			default:          rd_addr = fire_idx;
		endcase
	end
	assign rd_t   = t_q[rd_addr];
	assign rd_c   = c_q[rd_addr];
	assign rd_gap = gap_q[fire_idx];

	// Last-trigger lookahead: a gap, the per-tick limit, or a second frame wrap ends the tick
	assign gap_nz     = (rd_gap != '0);
	assign at_n_end   = (n_q == LAST_IDX);
	assign wrap_again = (fire_idx == LAST_IDX) && wrapped_now;
	assign fire_last  = gap_nz | at_n_end | wrap_again;
	assign disarm     = !gap_nz && !at_n_end && wrap_again;

	// Offset differences; all are non-negative after sorting
	assign d_gap      = {rd_t[OFFSET_W-1], rd_t} - {prev_q[OFFSET_W-1], prev_q};
	assign d_spread   = {rd_t[OFFSET_W-1], rd_t} - {base_q[OFFSET_W-1], base_q};
	assign d_last     = {prev_q[OFFSET_W-1], prev_q} - {base_q[OFFSET_W-1], base_q};
	assign gap_val    = {{(PERIOD_W-OFFSET_W){1'b0}}, d_gap[OFFSET_W-1:0]};
	assign spread_val = {{(PERIOD_W-OFFSET_W){1'b0}}, d_spread[OFFSET_W-1:0]};
	assign last_val   = {{(PERIOD_W-OFFSET_W){1'b0}}, d_last[OFFSET_W-1:0]};

	assign out_free = !out_valid_q || out_ready;

	// Status to the controller
	always_comb begin
		status.go_build  = (command == CMD_START) && !running_q;
		status.go_fire   = (command == CMD_TICK) && running_q && armed_q &&
		                   (countdown_q <= PERIOD_W'(1));
		status.scan_end  = (j_q == LAST_IDX);
		status.sort_end  = (i_q == PEN_IDX);
		status.gap_end   = (j_q == LAST_IDX);
		status.fire_done = fire_last;
		status.out_free  = out_free;
	end

	// Slot tables: load, swap and gap writes
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				for (int k = 0; k < NUM_CHANNELS; k++) begin
					if (k >= 1 && k <= NUM_REGS) begin
						t_q[k] <= $signed(offsets[(k >= 1 && k <= NUM_REGS) ? k - 1 : 0]);
					end else begin
						t_q[k] <= '0;
					end
					c_q[k] <= CW'(k);
				end
			end
			OP_SWAP_A: begin
				t_q[m_q] <= ti_q;
				c_q[m_q] <= ci_q;
			end
			OP_SWAP_B: begin
				t_q[i_q] <= min_q;
				c_q[i_q] <= cm_q;
			end
			OP_GAP: begin
				if (j_q != '0) begin
					gap_q[j_q - 1'b1] <= clamp_q ? '0 : gap_val;
				end
			end
			OP_LAST_GAP: begin
				gap_q[LAST_IDX] <= clamp_q ? period_q : period_q - last_val;
			end
			default: ;
		endcase
	end

	// Sort scratch registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_SEL: begin
				min_q <= rd_t;
				ti_q  <= rd_t;
				ci_q  <= rd_c;
				cm_q  <= rd_c;
				m_q   <= i_q;
			end
			OP_SCAN: begin
				if (rd_t < min_q) begin
					min_q <= rd_t;
					cm_q  <= rd_c;
					m_q   <= j_q;
				end
			end
			OP_SWAP_B: begin
				if (i_q == '0) begin
					base_q <= min_q;
				end
			end
			OP_SPREAD: clamp_q <= (spread_val > period_q);
			OP_GAP:    prev_q  <= rd_t;
			default: ;
		endcase
	end

	// Loop counters and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			j_q         <= '0;
			running_q   <= 1'b0;
			armed_q     <= 1'b0;
			wrapped_q   <= 1'b0;
			period_q    <= PERIOD_RESET;
			countdown_q <= '0;
			seq_q       <= '0;
			slot_idx_q  <= '0;
			n_q         <= '0;
		end else begin
			unique case (cmd.op)
				OP_ACCEPT: begin
					if (command == CMD_START && !running_q) begin
						period_q    <= period_us;
						slot_idx_q  <= LAST_IDX;
						seq_q       <= '1;
						countdown_q <= '0;
					end else if (command == CMD_STOP) begin
						running_q   <= 1'b0;
						armed_q     <= 1'b0;
						countdown_q <= '0;
					end else if (command == CMD_TICK && running_q && armed_q) begin
						if (countdown_q > PERIOD_W'(1)) begin
							countdown_q <= countdown_q - 1'b1;
						end else begin
							countdown_q <= '0;
							n_q         <= '0;
							wrapped_q   <= 1'b0;
						end
					end
				end
				OP_LOAD:   i_q <= '0;
				OP_SEL:    j_q <= i_q + 1'b1;
				OP_SCAN:   j_q <= j_q + 1'b1;
				OP_SWAP_B: i_q <= i_q + 1'b1;
				OP_SPREAD: j_q <= '0;
				OP_GAP:    j_q <= j_q + 1'b1;
				OP_LAST_GAP: begin
					running_q <= 1'b1;
					armed_q   <= 1'b1;
				end
				OP_FIRE: begin
					slot_idx_q <= fire_idx;
					seq_q      <= seq_fire;
					wrapped_q  <= wrapped_now;
					n_q        <= n_q + 1'b1;
					if (gap_nz) begin
						countdown_q <= rd_gap;
					end
					if (disarm) begin
						armed_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_FIRE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.op == OP_FIRE) begin
			chan_q <= rd_c[CHAN_W-1:0];
			oseq_q <= seq_fire;
			last_q <= fire_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign trigger_channel = chan_q;
	assign frame_seq       = oseq_q;
	assign last            = last_q;

endmodule

// ----- hdl/mcfts_checker.sv -----
// Port-level checker for the frame trigger sequencer, bound to the top level.
module mcfts_checker import mcfts_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                pready,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [CMD_W-1:0]    s_tuser,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [SEQ_W-1:0]    m_tdata,
	input logic [CHAN_W-1:0]   m_tuser,
	input logic                m_tlast
);

	// A stalled trigger holds its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("trigger changed while stalled");

	// More triggers of the same tick pending: no new request taken
	a_busy_fire: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("request accepted in the middle of a trigger burst");

	// Stop leaves the sequencer ready again in the cycle after it is taken
	a_stop_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_STOP |=> s_tready)
		else $error("not ready after stop");

	// Config port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind multi_channel_frame_trigger_sequencer mcfts_checker u_mcfts_checker (.*);
